// ===== sv/scxc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scxc_pkg
// Shared types, register indexes and key-schedule helpers for the
// segment-chained xor cipher.
// ----------------------------------------------------------------------------
package scxc_pkg;

    // field widths
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned SEG_W     = 16;
    localparam int unsigned MSG_W     = 24;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_KEY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_BYTES = 2'd2;

    // reset values of the configuration registers
    localparam logic [KEY_W-1:0] RST_START_KEY     = 32'd0;
    localparam logic [SEG_W-1:0] RST_SEGMENT_BYTES = 16'd64;
    localparam logic [MSG_W-1:0] RST_MESSAGE_BYTES = 24'd1;

    // reflected crc-32
    localparam logic [KEY_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [KEY_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    // running stream state
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SEG_W-1:0] offset;
        logic [MSG_W-1:0] remaining;
        logic [SEG_W-1:0] seg_len;
    } t_scxc_state;

    // key stream byte and end-of-message flag for the current byte
    typedef struct packed {
        logic [BYTE_W-1:0] key_byte;
        logic              last;
    } t_scxc_stream;

    // next segment key: crc-32 over the four key bytes, low byte first
    function automatic logic [KEY_W-1:0] key_successor(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] crc;
        crc = CRC_ONES ^ k;
        for (int i = 0; i < KEY_W; i++) begin
            crc = crc[0] ? (CRC_POLY ^ (crc >> 1)) : (crc >> 1);
        end
        return crc ^ CRC_ONES;
    endfunction

    // length of the segment that starts with rem bytes left
    function automatic logic [SEG_W-1:0] seg_len_for(input logic [SEG_W-1:0] seg_eff,
                                                     input logic [MSG_W-1:0] rem);
        logic [SEG_W-1:0] len;
        if (rem < {{(MSG_W-SEG_W){1'b0}}, seg_eff}) begin
            len = rem[SEG_W-1:0];
        end else begin
            len = seg_eff;
        end
        if (len == '0) begin
            len = {{(SEG_W-1){1'b0}}, 1'b1};
        end
        return len;
    endfunction

endpackage

// ===== sv/scxc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scxc_in_if
// Input byte channel: valid/ready handshake carrying one message byte.
// ----------------------------------------------------------------------------
interface scxc_in_if;
    import scxc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_in;

    modport source (output valid, output data_in, input ready);
    modport sink   (input valid, input data_in, output ready);

endinterface

// ===== sv/scxc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scxc_out_if
// Output byte channel: valid/ready handshake carrying the ciphered byte and
// the end-of-message flag.
// ----------------------------------------------------------------------------
interface scxc_out_if;
    import scxc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_out;
    logic              last;

    modport source (output valid, output data_out, output last, input ready);
    modport sink   (input valid, input data_out, input last, output ready);

endinterface

// ===== sv/scxc_keystream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scxc_keystream
// Selects the key stream byte for the current position in the segment:
// rotated key bytes over the word part, plain key bytes over the tail.
// ----------------------------------------------------------------------------
module scxc_keystream (
    input  scxc_pkg::t_scxc_state  i_state,
    output scxc_pkg::t_scxc_stream o_stream
);
    import scxc_pkg::*;

    logic [SEG_W-1:0]   word_part;
    logic [4:0]         rot_amt;
    logic [1:0]         lane;
    logic [2*KEY_W-1:0] key_dbl;
    logic [KEY_W-1:0]   key_rot;
    logic [KEY_W-1:0]   key_sel;
    logic [KEY_W-1:0]   key_shift;

    // word part of the segment is its length rounded down to whole words
    assign word_part = {i_state.seg_len[SEG_W-1:2], 2'b00};
    assign rot_amt   = i_state.offset[6:2];
    assign lane      = i_state.offset[1:0];

    // rotate left by word index mod 32
    assign key_dbl = {i_state.key, i_state.key};
    always_comb begin
        key_rot = key_dbl[KEY_W-1:0];
        key_rot = KEY_W'(key_dbl >> (6'd32 - {1'b0, rot_amt}));
    end

    // pick rotated or plain key, then the byte lane
    assign key_sel   = (i_state.offset < word_part) ? key_rot : i_state.key;
    assign key_shift = key_sel >> {lane, 3'b000};

    assign o_stream.key_byte = key_shift[BYTE_W-1:0];
    assign o_stream.last     = (i_state.remaining <= {{(MSG_W-1){1'b0}}, 1'b1});

endmodule

// ===== sv/scxc_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scxc_state
// Configuration registers and the running key, offset and length counters;
// advances once per processed byte and restarts at message end or on any
// register write.
// ----------------------------------------------------------------------------
module scxc_state (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [scxc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [scxc_pkg::KEY_W-1:0]          i_cfg_wdata,
    input  logic                                i_advance,
    input  logic                                i_last,
    output scxc_pkg::t_scxc_state               o_state
);
    import scxc_pkg::*;

    logic [KEY_W-1:0] r_start_key, n_start_key;
    logic [SEG_W-1:0] r_seg_bytes, n_seg_bytes;
    logic [MSG_W-1:0] r_msg_bytes, n_msg_bytes;
    t_scxc_state      r_state, n_state;

    logic             cfg_hit;
    logic [SEG_W-1:0] seg_eff;
    logic [MSG_W-1:0] msg_eff;
    logic [MSG_W-1:0] rem_dec;
    logic [SEG_W:0]   off_inc;

    // register write decode
    always_comb begin
        n_start_key = r_start_key;
        n_seg_bytes = r_seg_bytes;
        n_msg_bytes = r_msg_bytes;
        cfg_hit     = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_KEY: begin
                    n_start_key = i_cfg_wdata;
                    cfg_hit     = 1'b1;
                end
                CFG_SEGMENT_BYTES: begin
                    n_seg_bytes = i_cfg_wdata[SEG_W-1:0];
                    cfg_hit     = 1'b1;
                end
                CFG_MESSAGE_BYTES: begin
                    n_msg_bytes = i_cfg_wdata[MSG_W-1:0];
                    cfg_hit     = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // zero sizes count as one
    assign seg_eff = (n_seg_bytes == '0) ? {{(SEG_W-1){1'b0}}, 1'b1} : n_seg_bytes;
    assign msg_eff = (n_msg_bytes == '0) ? {{(MSG_W-1){1'b0}}, 1'b1} : n_msg_bytes;

    assign rem_dec = r_state.remaining - {{(MSG_W-1){1'b0}}, 1'b1};
    assign off_inc = {1'b0, r_state.offset} + {{SEG_W{1'b0}}, 1'b1};

    // stream state update
    always_comb begin
        n_state = r_state;
        if (cfg_hit || (i_advance && i_last)) begin
            n_state.key       = n_start_key;
            n_state.offset    = '0;
            n_state.remaining = msg_eff;
            n_state.seg_len   = seg_len_for(seg_eff, msg_eff);
        end else if (i_advance) begin
            n_state.remaining = rem_dec;
            if (off_inc >= {1'b0, r_state.seg_len}) begin
                n_state.key     = key_successor(r_state.key);
                n_state.offset  = '0;
                n_state.seg_len = seg_len_for(seg_eff, rem_dec);
            end else begin
                n_state.offset = off_inc[SEG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_key       <= RST_START_KEY;
            r_seg_bytes       <= RST_SEGMENT_BYTES;
            r_msg_bytes       <= RST_MESSAGE_BYTES;
            r_state.key       <= RST_START_KEY;
            r_state.offset    <= '0;
            r_state.remaining <= RST_MESSAGE_BYTES;
            r_state.seg_len   <= {{(SEG_W-1){1'b0}}, 1'b1};
        end else begin
            r_start_key <= n_start_key;
            r_seg_bytes <= n_seg_bytes;
            r_msg_bytes <= n_msg_bytes;
            r_state     <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// ===== sv/segment_chain_xor_cipher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_chain_xor_cipher_unit
// Segment-chained xor stream cipher, one message byte per transaction.
// ----------------------------------------------------------------------------
// The unit takes one byte per clock cycle and returns it xored with the key
// stream through an input register, then a result register. Throughput is
// one byte per cycle while results are taken: the key byte selection and
// the crc-32 key update at a segment end are both done in the single cycle
// in which a byte moves from the input register to the result register.
// While a result waits to be taken the input register can still take one
// byte, after which the input stalls until the result is taken.
// The final byte of each message is flagged with last, after which the
// stream restarts from the start key. A write to any register restarts the
// message; write registers only while no transaction is in flight.
module segment_chain_xor_cipher_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [scxc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [scxc_pkg::KEY_W-1:0]     i_cfg_wdata,
    scxc_in_if.sink                        i_in_ch,
    scxc_out_if.source                     o_out_ch
);
    import scxc_pkg::*;

    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_data;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_last;

    logic              in_fire;
    logic              advance;
    t_scxc_state       state;
    t_scxc_stream      stream;

    // byte moves to the result register when it is empty or being drained
    assign advance       = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready = !r_in_valid || advance;
    assign in_fire       = i_in_ch.valid && i_in_ch.ready;

    assign n_in_valid  = in_fire || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !o_out_ch.ready);

    scxc_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (advance),
        .i_last      (stream.last),
        .o_state     (state)
    );

    scxc_keystream u_keystream (
        .i_state  (state),
        .o_stream (stream)
    );

    // handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_data <= i_in_ch.data_in;
        end
        if (advance) begin
            r_out_data <= r_in_data ^ stream.key_byte;
            r_out_last <= stream.last;
        end
    end

    assign o_out_ch.valid    = r_out_valid;
    assign o_out_ch.data_out = r_out_data;
    assign o_out_ch.last     = r_out_last;

`ifndef SYNTHESIS
    // offset always stays inside the current segment
    a_offset_in_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        state.offset < state.seg_len)
        else $error("segment offset outside segment");

    // current segment never runs past the end of the message
    a_segment_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (({{(MSG_W-SEG_W){1'b0}}, state.seg_len} - {{(MSG_W-SEG_W){1'b0}}, state.offset})
            <= state.remaining) && (state.remaining != '0))
        else $error("segment extends past message end");

    // the byte after a flagged final byte starts a new message
    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && stream.last) |=> (state.offset == '0))
        else $error("no restart after final byte");

    // a held input byte blocks new input transactions
    a_input_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |-> !i_in_ch.ready)
        else $error("input accepted while input register is held");
`endif

endmodule
